>>> sv/fadc_pkg.sv
// Shared types, codes and field widths for the follow alignment and distance controller.
package fadc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned ALIGN_W  = 10;
   localparam int unsigned DWELL_W  = 13;
   localparam int unsigned SPEED_W  = 7;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 24;

   typedef logic [1:0] move_type;
   localparam move_type MOVE_STOP  = 2'd0;
   localparam move_type MOVE_FWD   = 2'd1;
   localparam move_type MOVE_LEFT  = 2'd2;
   localparam move_type MOVE_RIGHT = 2'd3;

   typedef logic [1:0] side_type;
   localparam side_type SIDE_NONE   = 2'd0;
   localparam side_type SIDE_LEFT   = 2'd1;
   localparam side_type SIDE_CENTER = 2'd2;
   localparam side_type SIDE_RIGHT  = 2'd3;

   typedef logic [1:0] range_type;
   localparam range_type RANGE_UNKNOWN = 2'd0;
   localparam range_type RANGE_FAR     = 2'd1;
   localparam range_type RANGE_GOOD    = 2'd2;
   localparam range_type RANGE_NEAR    = 2'd3;

   typedef logic [2:0] phase_type;
   localparam phase_type PHASE_ACQUIRE  = 3'd0;
   localparam phase_type PHASE_HOLD     = 3'd1;
   localparam phase_type PHASE_ALIGN    = 3'd2;
   localparam phase_type PHASE_APPROACH = 3'd3;
   localparam phase_type PHASE_LOST     = 3'd4;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FAR_ENTER   = 3'd0;
   localparam csr_idx_type CSR_FAR_EXIT    = 3'd1;
   localparam csr_idx_type CSR_NEAR_EXIT   = 3'd2;
   localparam csr_idx_type CSR_NEAR_ENTER  = 3'd3;
   localparam csr_idx_type CSR_ALIGN_ENTER = 3'd4;
   localparam csr_idx_type CSR_ALIGN_EXIT  = 3'd5;
   localparam csr_idx_type CSR_ENTER_DWELL = 3'd6;
   localparam csr_idx_type CSR_EXIT_DWELL  = 3'd7;

   localparam logic OPCODE_LOST = 1'b1;

endpackage

>>> sv/follow_align_distance_controller_core.sv
// Follow controller core: distance hysteresis, alignment debounce and chassis command.
// The response passes through the input register, then the response register.
// Throughput: one request per cycle while no response waits; all decision logic sits in one stage after the input reg.
// Back pressure: the response register stalls the input stage only while a response waits.
// Reset: synchronous active high; clears evidence flags and state (not the start times), restores register defaults,
// empties both stages. No clearing pass is needed.
module follow_align_distance_controller_core
   import fadc_pkg::*;
#(
   parameter int unsigned STABLE_MS     = 500,
   parameter int unsigned MIN_MOTION_MS = 200,
   parameter int unsigned DRIVE_SPEED   = 30,
   parameter int unsigned SPIN_SPEED    = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // now_ms[31:0], box_height[47:32], head_offset[59:48], head_fresh[60], zero[63:61]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // opcode[0]
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // chassis_move[1:0], move_speed[8:2], command_sent[9], follow_phase[12:10],
   // range_class[14:13], head_side[16:15], zero[23:17]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wr_data
);

   // configuration
   logic [HEIGHT_W-1:0] far_enter_ff, far_exit_ff, near_exit_ff, near_enter_ff;
   logic [ALIGN_W-1:0]  align_enter_ff, align_exit_ff;
   logic [DWELL_W-1:0]  enter_dwell_ff, exit_dwell_ff;

   // input stage
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_op_ff;
   logic [TIME_W-1:0]          s1_now_ff;
   logic [HEIGHT_W-1:0]        s1_height_ff;
   logic [OFFSET_W-1:0]        s1_offset_ff;
   logic                       s1_fresh_ff;

   // evidence
   range_type         range_ff, range_in;
   logic              stable_valid_ff, stable_valid_in;
   logic [TIME_W-1:0] stable_start_ff, stable_start_in;
   logic              cand_valid_ff, cand_valid_in;
   logic [TIME_W-1:0] cand_start_ff, cand_start_in;
   side_type          cand_side_ff, cand_side_in;
   logic              exit_valid_ff, exit_valid_in;
   logic [TIME_W-1:0] exit_start_ff, exit_start_in;
   logic              motion_valid_ff, motion_valid_in;
   logic [TIME_W-1:0] motion_start_ff, motion_start_in;
   logic              aligning_ff, aligning_in;
   move_type          last_move_ff, last_move_in;
   logic              live_ff, live_in;

   // response stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic out_ready, s1_fire, req_fire;

   localparam logic [TIME_W-1:0] STABLE_T = TIME_W'(STABLE_MS);
   localparam logic [TIME_W-1:0] MIN_MOTION_T = TIME_W'(MIN_MOTION_MS);
   localparam logic [SPEED_W-1:0] FWD_SPD = SPEED_W'(DRIVE_SPEED);
   localparam logic [SPEED_W-1:0] ROT_SPD = SPEED_W'(SPIN_SPEED);

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decision logic
   always_comb begin
      logic [OFFSET_W-1:0] mag;
      logic                neg;
      side_type            side;
      side_type            firm;
      side_type            lean;
      logic                sent;
      phase_type           phase;
      logic                al;
      logic                pending;
      logic [TIME_W-1:0]   moved;
      logic [TIME_W-1:0]   exit_el;
      logic [TIME_W-1:0]   cand_el;
      logic [TIME_W-1:0]   stable_el;
      move_type            mv;
      logic [SPEED_W-1:0]  speed;

      range_in        = range_ff;
      stable_valid_in = stable_valid_ff;
      stable_start_in = stable_start_ff;
      cand_valid_in   = cand_valid_ff;
      cand_start_in   = cand_start_ff;
      cand_side_in    = cand_side_ff;
      exit_valid_in   = exit_valid_ff;
      exit_start_in   = exit_start_ff;
      motion_valid_in = motion_valid_ff;
      motion_start_in = motion_start_ff;
      aligning_in     = aligning_ff;
      last_move_in    = last_move_ff;
      live_in         = live_ff;
      sent    = 1'b0;
      phase   = PHASE_ACQUIRE;
      al      = 1'b0;
      pending = 1'b0;
      moved   = '0;
      exit_el = '0;
      cand_el = '0;
      mv      = MOVE_STOP;

      neg = s1_offset_ff[OFFSET_W-1];
      mag = neg ? (~s1_offset_ff + OFFSET_W'(1)) : s1_offset_ff;
      lean = neg ? SIDE_LEFT : SIDE_RIGHT;
      if (mag >= OFFSET_W'(align_enter_ff) && s1_offset_ff != '0) begin
         firm = lean;
      end else if (align_enter_ff == '0) begin
         firm = SIDE_RIGHT;
      end else begin
         firm = SIDE_CENTER;
      end
      if (!s1_fresh_ff) begin
         side = SIDE_NONE;
      end else if (mag <= OFFSET_W'(align_exit_ff)) begin
         side = SIDE_CENTER;
      end else begin
         side = lean;
      end

      stable_el = '0;
      if (s1_op_ff == OPCODE_LOST) begin
         if (live_ff) begin
            sent = 1'b1;
         end
         range_in        = RANGE_UNKNOWN;
         stable_valid_in = 1'b0;
         cand_valid_in   = 1'b0;
         cand_side_in    = SIDE_NONE;
         exit_valid_in   = 1'b0;
         motion_valid_in = 1'b0;
         aligning_in     = 1'b0;
         last_move_in    = MOVE_STOP;
         live_in         = 1'b0;
         phase           = PHASE_LOST;
      end else begin
         live_in = 1'b1;
         // distance hysteresis
         case (range_ff)
            RANGE_FAR: begin
               if (s1_height_ff >= far_exit_ff) begin
                  range_in = (s1_height_ff >= near_enter_ff) ? RANGE_NEAR : RANGE_GOOD;
               end
            end
            RANGE_NEAR: begin
               if (s1_height_ff <= near_exit_ff) begin
                  range_in = (s1_height_ff <= far_enter_ff) ? RANGE_FAR : RANGE_GOOD;
               end
            end
            default: begin
               if (s1_height_ff <= far_enter_ff) begin
                  range_in = RANGE_FAR;
               end else if (s1_height_ff >= near_enter_ff) begin
                  range_in = RANGE_NEAR;
               end else begin
                  range_in = RANGE_GOOD;
               end
            end
         endcase
         if (!stable_valid_ff) begin
            stable_valid_in = 1'b1;
            stable_start_in = s1_now_ff;
         end
         stable_el = s1_now_ff - stable_start_in;
         if (stable_el < STABLE_T) begin
            if (last_move_ff != MOVE_STOP) begin
               sent = 1'b1;
            end
            last_move_in = MOVE_STOP;
            phase = PHASE_ACQUIRE;
         end else if (!s1_fresh_ff) begin
            sent = 1'b1;
            last_move_in = MOVE_STOP;
            phase = PHASE_HOLD;
         end else begin
            // alignment debounce
            if (aligning_ff) begin
               if (mag <= OFFSET_W'(align_exit_ff)) begin
                  if (!exit_valid_ff) begin
                     exit_valid_in = 1'b1;
                     exit_start_in = s1_now_ff;
                  end
                  moved   = motion_valid_ff ? (s1_now_ff - motion_start_ff) : '0;
                  exit_el = s1_now_ff - exit_start_in;
                  if (last_move_in != MOVE_STOP) begin
                     sent = 1'b1;
                  end
                  last_move_in = MOVE_STOP;
                  if (exit_el >= TIME_W'(exit_dwell_ff) &&
                      (moved >= MIN_MOTION_T || exit_el >= (MIN_MOTION_T - moved))) begin
                     aligning_in   = 1'b0;
                     cand_side_in  = SIDE_NONE;
                     exit_valid_in = 1'b0;
                     cand_valid_in = 1'b0;
                  end
                  al = aligning_in;
               end else begin
                  exit_valid_in = 1'b0;
                  if (lean != cand_side_ff) begin
                     sent          = 1'b1;
                     last_move_in  = MOVE_STOP;
                     aligning_in   = 1'b0;
                     cand_side_in  = lean;
                     cand_valid_in = 1'b1;
                     cand_start_in = s1_now_ff;
                     al            = 1'b0;
                  end else begin
                     al = 1'b1;
                  end
               end
            end else if (firm == SIDE_CENTER) begin
               cand_side_in  = SIDE_NONE;
               cand_valid_in = 1'b0;
            end else if (cand_side_ff != firm || !cand_valid_ff) begin
               cand_side_in  = firm;
               cand_valid_in = 1'b1;
               cand_start_in = s1_now_ff;
            end else begin
               cand_el = s1_now_ff - cand_start_ff;
               if (cand_el >= TIME_W'(enter_dwell_ff)) begin
                  aligning_in     = 1'b1;
                  cand_valid_in   = 1'b0;
                  motion_valid_in = 1'b1;
                  motion_start_in = s1_now_ff;
                  al              = 1'b1;
               end
            end
            pending = cand_valid_in || exit_valid_in;
            if (exit_valid_in || (!al && pending)) begin
               if (last_move_in != MOVE_STOP) begin
                  sent = 1'b1;
               end
               last_move_in = MOVE_STOP;
               phase = PHASE_ALIGN;
            end else if (al || range_in == RANGE_FAR) begin
               if (al) begin
                  mv = (cand_side_in == SIDE_LEFT) ? MOVE_LEFT : MOVE_RIGHT;
                  phase = PHASE_ALIGN;
               end else begin
                  mv = MOVE_FWD;
                  phase = PHASE_APPROACH;
               end
               sent = 1'b1;
               if (mv != last_move_in) begin
                  motion_valid_in = 1'b1;
                  motion_start_in = s1_now_ff;
               end
               last_move_in = mv;
            end else begin
               if (last_move_in != MOVE_STOP) begin
                  sent = 1'b1;
               end
               last_move_in = MOVE_STOP;
               phase = PHASE_HOLD;
            end
         end
      end

      case (last_move_in)
         MOVE_STOP: speed = '0;
         MOVE_FWD:  speed = FWD_SPD;
         default:   speed = ROT_SPD;
      endcase
      rsp_data_in = {7'd0, side, range_in, phase, sent, speed, last_move_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         far_enter_ff    <= 16'd9830;
         far_exit_ff     <= 16'd13107;
         near_exit_ff    <= 16'd45875;
         near_enter_ff   <= 16'd52428;
         align_enter_ff  <= 10'd200;
         align_exit_ff   <= 10'd80;
         enter_dwell_ff  <= 13'd300;
         exit_dwell_ff   <= 13'd300;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         range_ff        <= RANGE_UNKNOWN;
         stable_valid_ff <= 1'b0;
         cand_valid_ff   <= 1'b0;
         cand_side_ff    <= SIDE_NONE;
         exit_valid_ff   <= 1'b0;
         motion_valid_ff <= 1'b0;
         aligning_ff     <= 1'b0;
         last_move_ff    <= MOVE_STOP;
         live_ff         <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FAR_ENTER:   far_enter_ff   <= csr_wr_data;
               CSR_FAR_EXIT:    far_exit_ff    <= csr_wr_data;
               CSR_NEAR_EXIT:   near_exit_ff   <= csr_wr_data;
               CSR_NEAR_ENTER:  near_enter_ff  <= csr_wr_data;
               CSR_ALIGN_ENTER: align_enter_ff <= csr_wr_data[ALIGN_W-1:0];
               CSR_ALIGN_EXIT:  align_exit_ff  <= csr_wr_data[ALIGN_W-1:0];
               CSR_ENTER_DWELL: enter_dwell_ff <= csr_wr_data[DWELL_W-1:0];
               CSR_EXIT_DWELL:  exit_dwell_ff  <= csr_wr_data[DWELL_W-1:0];
               default: ;
            endcase
         end
         if (s1_fire) begin
            range_ff        <= range_in;
            stable_valid_ff <= stable_valid_in;
            cand_valid_ff   <= cand_valid_in;
            cand_side_ff    <= cand_side_in;
            exit_valid_ff   <= exit_valid_in;
            motion_valid_ff <= motion_valid_in;
            aligning_ff     <= aligning_in;
            last_move_ff    <= last_move_in;
            live_ff         <= live_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff     <= req_tuser;
         s1_now_ff    <= req_tdata[31:0];
         s1_height_ff <= req_tdata[47:32];
         s1_offset_ff <= req_tdata[59:48];
         s1_fresh_ff  <= req_tdata[60];
      end
      if (s1_fire) begin
         stable_start_ff <= stable_start_in;
         cand_start_ff   <= cand_start_in;
         exit_start_ff   <= exit_start_in;
         motion_start_ff <= motion_start_in;
         rsp_data_ff     <= rsp_data_in;
      end
   end

   // stop carries zero speed, moves never do
   a_speed_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[1:0] == MOVE_STOP) == (rsp_data_ff[8:2] == '0)))
      else $error("speed and move disagree");

   a_align_live: assert property (@(posedge clock) disable iff (reset)
      aligning_ff |-> live_ff)
      else $error("aligning without live target");

   a_lost_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_op_ff == OPCODE_LOST) |=> (range_ff == RANGE_UNKNOWN && !aligning_ff &&
                                 !stable_valid_ff && last_move_ff == MOVE_STOP))
      else $error("loss did not clear evidence");

   a_lost_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[12:10] == PHASE_LOST) |-> rsp_data_ff[14:13] == RANGE_UNKNOWN)
      else $error("lost phase with range class");

   a_approach: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[12:10] == PHASE_APPROACH) |->
         (rsp_data_ff[1:0] == MOVE_FWD && rsp_data_ff[9]))
      else $error("approach without forward command");

endmodule

>>> dv/tb_follow_align_distance_controller_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the follow controller core: stream driver, monitor and predictor.
module tb_follow_align_distance_controller_core;
   import fadc_pkg::*;

   localparam int unsigned SETTLE_MS    = 500;
   localparam int unsigned MIN_RUN_MS   = 200;
   localparam int unsigned FWD_SPEED    = 30;
   localparam int unsigned TURN_SPEED   = 30;
   localparam logic        OP_TRACK     = 1'b0;
   localparam logic        OP_LOST      = OPCODE_LOST;
   localparam int unsigned PHASE_ITEMS  = 150;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned TIMEOUT_NS   = 5_000_000;

   typedef struct {
      logic               opcode;
      logic [31:0]        now_ms;
      logic [15:0]        height;
      logic signed [11:0] offset;
      logic               fresh;
   } sighting_type;

   typedef struct {
      move_type   move;
      logic [6:0] speed;
      logic       sent;
      phase_type  phase;
      range_type  range_cls;
      side_type   side;
   } command_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   csr_idx_type           csr_index   = CSR_FAR_ENTER;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   follow_align_distance_controller_core #(
      .STABLE_MS     (SETTLE_MS),
      .MIN_MOTION_MS (MIN_RUN_MS),
      .DRIVE_SPEED   (FWD_SPEED),
      .SPIN_SPEED    (TURN_SPEED)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // thresholds as the block holds them
   logic [15:0] far_enter   = 16'd9830;
   logic [15:0] far_exit    = 16'd13107;
   logic [15:0] near_exit   = 16'd45875;
   logic [15:0] near_enter  = 16'd52428;
   logic [9:0]  align_enter = 10'd200;
   logic [9:0]  align_exit  = 10'd80;
   logic [12:0] enter_dwell = 13'd300;
   logic [12:0] exit_dwell  = 13'd300;

   // tracking state
   range_type   range_now;
   bit          seen_ok;
   logic [31:0] seen_t0;
   bit          cand_ok;
   logic [31:0] cand_t0;
   side_type    cand_side;
   bit          center_ok;
   logic [31:0] center_t0;
   bit          motion_ok;
   logic [31:0] motion_t0;
   bit          turning;
   move_type    cur_move;
   bit          tracking;
   bit          cmd_out;

   sighting_type sighting_q[$];
   command_type  command_q[$];
   int unsigned pushed_cnt   = 0;
   int unsigned accepted_cnt = 0;
   int unsigned rsp_seen     = 0;
   int unsigned mismatches   = 0;
   logic [31:0] stamp_ms     = '0;

   function automatic void clear_track();
      range_now = RANGE_UNKNOWN;
      seen_ok   = 1'b0; seen_t0   = '0;
      cand_ok   = 1'b0; cand_t0   = '0; cand_side = SIDE_NONE;
      center_ok = 1'b0; center_t0 = '0;
      motion_ok = 1'b0; motion_t0 = '0;
      turning   = 1'b0;
      cur_move  = MOVE_STOP;
      tracking  = 1'b0;
   endfunction

   function automatic void apply_reg(csr_idx_type idx, logic [15:0] val);
      case (idx)
         CSR_FAR_ENTER:   far_enter   = val;
         CSR_FAR_EXIT:    far_exit    = val;
         CSR_NEAR_EXIT:   near_exit   = val;
         CSR_NEAR_ENTER:  near_enter  = val;
         CSR_ALIGN_ENTER: align_enter = val[9:0];
         CSR_ALIGN_EXIT:  align_exit  = val[9:0];
         CSR_ENTER_DWELL: enter_dwell = val[12:0];
         CSR_EXIT_DWELL:  exit_dwell  = val[12:0];
         default: ;
      endcase
   endfunction

   function automatic void halt(bit force_send);
      if (force_send || cur_move != MOVE_STOP) cmd_out = 1'b1;
      cur_move = MOVE_STOP;
   endfunction

   function automatic void drive_move(move_type mv, logic [31:0] now);
      cmd_out = 1'b1;
      if (mv != cur_move) begin
         motion_ok = 1'b1;
         motion_t0 = now;
      end
      cur_move = mv;
   endfunction

   function automatic void sort_range(logic [15:0] h);
      if (range_now == RANGE_FAR) begin
         if (h >= far_exit) range_now = (h >= near_enter) ? RANGE_NEAR : RANGE_GOOD;
      end else if (range_now == RANGE_NEAR) begin
         if (h <= near_exit) range_now = (h <= far_enter) ? RANGE_FAR : RANGE_GOOD;
      end else if (h <= far_enter) begin
         range_now = RANGE_FAR;
      end else if (h >= near_enter) begin
         range_now = RANGE_NEAR;
      end else begin
         range_now = RANGE_GOOD;
      end
   endfunction

   // alignment debounce; returns 1 while alignment (the turning state) is in progress
   function automatic bit align_step(int off, logic [31:0] now);
      int          mag;
      side_type    firm_side;
      side_type    lean_side;
      logic [31:0] moved;
      logic [31:0] held;
      longint      need;
      mag = off < 0 ? -off : off;
      if (mag >= int'(align_enter) && off != 0) firm_side = off < 0 ? SIDE_LEFT : SIDE_RIGHT;
      else if (align_enter == '0) firm_side = SIDE_RIGHT;
      else firm_side = SIDE_CENTER;
      lean_side = off < 0 ? SIDE_LEFT : SIDE_RIGHT;

      if (turning) begin
         if (mag <= int'(align_exit)) begin
            if (!center_ok) begin
               center_ok = 1'b1;
               center_t0 = now;
            end
            moved = motion_ok ? now - motion_t0 : 32'd0;
            need  = longint'(MIN_RUN_MS) - longint'(moved);
            if (need < longint'(exit_dwell)) need = longint'(exit_dwell);
            halt(1'b0);
            held = now - center_t0;
            if (longint'(held) >= need) begin
               turning   = 1'b0;
               cand_side = SIDE_NONE;
               center_ok = 1'b0;
               cand_ok   = 1'b0;
            end
            return turning;
         end
         center_ok = 1'b0;
         if (lean_side != cand_side) begin
            // direction reversed while turning
            halt(1'b1);
            turning   = 1'b0;
            cand_side = lean_side;
            cand_ok   = 1'b1;
            cand_t0   = now;
            return 1'b0;
         end
         return 1'b1;
      end
      if (firm_side == SIDE_CENTER) begin
         cand_side = SIDE_NONE;
         cand_ok   = 1'b0;
         return 1'b0;
      end
      if (cand_side != firm_side || !cand_ok) begin
         cand_side = firm_side;
         cand_ok   = 1'b1;
         cand_t0   = now;
         return 1'b0;
      end
      held = now - cand_t0;
      if (held < {19'd0, enter_dwell}) return 1'b0;
      turning   = 1'b1;
      cand_ok   = 1'b0;
      motion_ok = 1'b1;
      motion_t0 = now;
      return 1'b1;
   endfunction

   function automatic command_type follow_predict(sighting_type s);
      command_type c;
      int          off;
      int          mag;
      logic [31:0] seen_for;
      bit          rotating;
      bit          waiting;
      off = int'(s.offset);
      mag = off < 0 ? -off : off;
      c.side = SIDE_NONE;
      if (s.fresh) c.side = mag <= int'(align_exit) ? SIDE_CENTER
                          : (off < 0 ? SIDE_LEFT : SIDE_RIGHT);
      cmd_out = 1'b0;
      if (s.opcode == OP_LOST) begin
         if (tracking) halt(1'b1);
         clear_track();
         c.phase = PHASE_LOST;
      end else begin
         tracking = 1'b1;
         sort_range(s.height);
         if (!seen_ok) begin
            seen_ok = 1'b1;
            seen_t0 = s.now_ms;
         end
         seen_for = s.now_ms - seen_t0;
         if (seen_for < SETTLE_MS) begin
            halt(1'b0);
            c.phase = PHASE_ACQUIRE;
         end else if (!s.fresh) begin
            halt(1'b1);
            c.phase = PHASE_HOLD;
         end else begin
            rotating = align_step(off, s.now_ms);
            waiting  = cand_ok || center_ok;
            if (center_ok) begin
               halt(1'b0);
               c.phase = PHASE_ALIGN;
            end else if (rotating) begin
               drive_move(cand_side == SIDE_LEFT ? MOVE_LEFT : MOVE_RIGHT, s.now_ms);
               c.phase = PHASE_ALIGN;
            end else if (waiting) begin
               halt(1'b0);
               c.phase = PHASE_ALIGN;
            end else if (range_now == RANGE_FAR) begin
               drive_move(MOVE_FWD, s.now_ms);
               c.phase = PHASE_APPROACH;
            end else begin
               halt(1'b0);
               c.phase = PHASE_HOLD;
            end
         end
      end
      c.move      = cur_move;
      c.speed     = cur_move == MOVE_STOP ? 7'd0
                  : (cur_move == MOVE_FWD ? 7'(FWD_SPEED) : 7'(TURN_SPEED));
      c.sent      = cmd_out;
      c.range_cls = range_now;
      return c;
   endfunction

   function automatic int unsigned pause_draw(inout bit steady);
      if ($urandom_range(0, 31) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // request driver
   sighting_type in_flight;
   int unsigned req_gap    = 0;
   bit          req_steady = 1'b0;

   always @(posedge clock) begin
      logic show;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         show = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            command_q.push_back(follow_predict(in_flight));
            accepted_cnt++;
            req_gap = pause_draw(req_steady);
         end
         if (!show) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (sighting_q.size() != 0) begin
               in_flight = sighting_q.pop_front();
               req_tdata <= {3'b000, in_flight.fresh, in_flight.offset, in_flight.height,
                             in_flight.now_ms};
               req_tuser <= in_flight.opcode;
               show = 1'b1;
            end
         end
         req_tvalid <= show;
      end
   end

   // response monitor
   int unsigned rsp_hold   = 0;
   bit          rsp_steady = 1'b0;

   always @(posedge clock) begin
      command_type got;
      command_type want;
      int unsigned hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         hold = rsp_hold;
         if (rsp_tvalid && rsp_tready) begin
            got.move      = rsp_tdata[1:0];
            got.speed     = rsp_tdata[8:2];
            got.sent      = rsp_tdata[9];
            got.phase     = rsp_tdata[12:10];
            got.range_cls = rsp_tdata[14:13];
            got.side      = rsp_tdata[16:15];
            if (command_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no request outstanding: %h",
                           rsp_seen, rsp_tdata);
            end else begin
               want = command_q.pop_front();
               if (got.move !== want.move || got.speed !== want.speed ||
                   got.sent !== want.sent || got.phase !== want.phase ||
                   got.range_cls !== want.range_cls || got.side !== want.side) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response %0d: expected move %0d speed %0d sent %0d phase %0d",
                               " range %0d side %0d, got move %0d speed %0d sent %0d",
                               " phase %0d range %0d side %0d"},
                              rsp_seen, want.move, want.speed, want.sent, want.phase,
                              want.range_cls, want.side, got.move, got.speed, got.sent,
                              got.phase, got.range_cls, got.side);
               end
            end
            rsp_seen++;
            hold = pause_draw(rsp_steady);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_hold = hold;
         rsp_tready <= (hold == 0);
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic see(logic op, int unsigned adv_ms, logic [15:0] h, int off, logic fresh);
      sighting_type s;
      stamp_ms += adv_ms;
      s.opcode = op;
      s.now_ms = stamp_ms;
      s.height = h;
      s.offset = off[11:0];
      s.fresh  = fresh;
      sighting_q.push_back(s);
      pushed_cnt++;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      apply_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_all(logic [15:0] fe, logic [15:0] fx, logic [15:0] nx,
                            logic [15:0] ne, logic [15:0] ae, logic [15:0] ax,
                            logic [15:0] ed, logic [15:0] xd);
      write_reg(CSR_FAR_ENTER, fe);
      write_reg(CSR_FAR_EXIT, fx);
      write_reg(CSR_NEAR_EXIT, nx);
      write_reg(CSR_NEAR_ENTER, ne);
      write_reg(CSR_ALIGN_ENTER, ae);
      write_reg(CSR_ALIGN_EXIT, ax);
      write_reg(CSR_ENTER_DWELL, ed);
      write_reg(CSR_EXIT_DWELL, xd);
      csr_wr_en <= 1'b0;
   endtask

   // hold off until every request has been answered
   task automatic drain();
      do @(posedge clock);
      while (accepted_cnt != pushed_cnt || command_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_height();
      int r;
      r = $urandom_range(0, 6);
      case (r)
         0: return $urandom_range(0, 65535);
         1: return clamp(int'(far_enter) + $urandom_range(0, 1200) - 600, 0, 65535);
         2: return clamp(int'(far_exit) + $urandom_range(0, 1200) - 600, 0, 65535);
         3: return clamp(int'(near_exit) + $urandom_range(0, 1200) - 600, 0, 65535);
         4: return clamp(int'(near_enter) + $urandom_range(0, 1200) - 600, 0, 65535);
         5: return $urandom_range(0, 1) ? 65535 : 0;
         default: return $urandom_range(16000, 40000);
      endcase
   endfunction

   function automatic int pick_offset();
      int r;
      int mag;
      r = $urandom_range(0, 5);
      case (r)
         0:       mag = $urandom_range(0, align_exit);
         1, 2:    mag = int'(align_enter) + $urandom_range(0, 300);
         3:       mag = $urandom_range(0, align_enter);
         4:       return int'($urandom_range(0, 4095)) - 2048;
         default: return $urandom_range(0, 1) ? 2047 : -2048;
      endcase
      return clamp($urandom_range(0, 1) ? -mag : mag, -2048, 2047);
   endfunction

   function automatic int unsigned pick_adv(int unsigned adv_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r == 0) return $urandom;
      if (r < 4) return 0;
      return $urandom_range(5, adv_hi);
   endfunction

   task automatic random_run(int unsigned count);
      int unsigned made;
      int unsigned len;
      int unsigned adv_hi;
      int unsigned k;
      int          aim;
      int          h_base;
      int          off;
      int          h;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 2) != 0) begin
            see(OP_LOST, $urandom_range(0, 200), 16'($urandom), int'($urandom),
                1'($urandom_range(0, 1)));
            made++;
            if ($urandom_range(0, 4) == 0 && made < count) begin
               see(OP_LOST, $urandom_range(0, 200), 16'($urandom), int'($urandom),
                   1'($urandom_range(0, 1)));
               made++;
            end
         end
         len    = $urandom_range(8, 40);
         h_base = pick_height();
         aim    = pick_offset();
         adv_hi = 60 + (enter_dwell > exit_dwell ? enter_dwell : exit_dwell) / 6;
         for (k = 0; k < len && made < count; k++) begin
            if ($urandom_range(0, 4) == 0) aim = pick_offset();
            if ($urandom_range(0, 5) == 0) h_base = pick_height();
            off = aim;
            if ($urandom_range(0, 2) == 0) off = clamp(aim + $urandom_range(0, 40) - 20,
                                                       -2048, 2047);
            h = clamp(h_base + $urandom_range(0, 400) - 200, 0, 65535);
            see(OP_TRACK, pick_adv(adv_hi), h[15:0], off, $urandom_range(0, 19) != 0);
            made++;
         end
      end
   endtask

   task automatic directed_run();
      stamp_ms = 32'hFFFF_FE00;  // crosses the 32-bit wrap below
      see(OP_LOST,    0, 16'd0,     0,     1'b0);  // loss with nothing tracked
      see(OP_TRACK,   0, 16'd0,     0,     1'b1);  // first sighting, far
      see(OP_TRACK, 100, 16'hFFFF,  0,     1'b1);  // settling, near
      see(OP_TRACK, 450, 16'd0,     0,     1'b1);  // settled, far: forward
      see(OP_TRACK,  50, 16'd0,     0,     1'b1);  // forward repeated
      see(OP_TRACK,  50, 16'd0,     0,     1'b0);  // stale head: forced stop
      see(OP_TRACK,  50, 16'd30000, 0,     1'b1);  // good range, already stopped
      see(OP_TRACK,  20, 16'd30000, 2047,  1'b1);  // right candidate
      see(OP_TRACK,  40, 16'd30000, 400,   1'b1);
      see(OP_TRACK, 300, 16'd30000, 300,   1'b1);  // dwell met: rotate right
      see(OP_TRACK,  50, 16'd30000, 250,   1'b1);  // rotate repeated
      see(OP_TRACK,  30, 16'd30000, -300,  1'b1);  // reversal: forced stop
      see(OP_TRACK, 100, 16'd30000, -500,  1'b1);
      see(OP_TRACK, 300, 16'd30000, -2048, 1'b1);  // rotate left
      see(OP_TRACK,  50, 16'd30000, 10,    1'b1);  // centered, exit dwell starts
      see(OP_TRACK, 100, 16'd30000, -80,   1'b1);
      see(OP_TRACK, 250, 16'd30000, 80,    1'b1);  // alignment ends
      see(OP_TRACK,  50, 16'd60000, -150,  1'b1);  // weak offset, near
      see(OP_TRACK,  50, 16'd40000, 0,     1'b1);  // back to good
      see(OP_TRACK,  50, 16'd13107, 2047,  1'b0);
      see(OP_LOST,   50, 16'd0,     0,     1'b1);  // loss while tracked
      see(OP_LOST,   50, 16'd0,     0,     1'b1);  // repeated loss
   endtask

   initial begin
      logic [15:0] fe;
      logic [15:0] nx;
      logic [15:0] ae;
      clear_track();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed_run();
      random_run(PHASE_ITEMS);

      drain();
      write_all(16'd0, 16'd65535, 16'd0, 16'd65535, 16'd700, 16'd0, 16'd0, 16'd0);
      random_run(PHASE_ITEMS);

      drain();
      write_all(16'd65535, 16'd0, 16'd65535, 16'd0, 16'd20, 16'd699, 16'd5000, 16'd5000);
      random_run(PHASE_ITEMS);

      drain();
      fe = 16'($urandom_range(2000, 20000));
      nx = 16'($urandom_range(30000, 50000));
      ae = 16'($urandom_range(20, 700));
      write_all(fe, fe + 16'($urandom_range(0, 8000)), nx, nx + 16'($urandom_range(0, 15000)),
                ae, 16'($urandom_range(0, ae - 1)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 600)));
      random_run(PHASE_ITEMS);

      drain();
      write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'h03FF,
                16'd0, 16'h1FFF);
      random_run(PHASE_ITEMS);

      drain();
      write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      random_run(PHASE_ITEMS);

      drain();
      write_all(16'd9830, 16'd13107, 16'd45875, 16'd52428, 16'd200, 16'd80, 16'd300, 16'd300);
      random_run(PHASE_ITEMS);

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && command_q.size() == 0)
         $display("tb_follow_align_distance_controller_core: done, clean");
      else
         $display("tb_follow_align_distance_controller_core: done, errors");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_follow_align_distance_controller_core: done, errors");
      $finish;
   end

endmodule

>>> files.f
sv/fadc_pkg.sv
sv/follow_align_distance_controller_core.sv
dv/tb_follow_align_distance_controller_core.sv
